// ===== rtl/tle_pkg.sv =====
// Shared types, constants and register map of the terminal line editor.
package tle_pkg;

   // Line store geometry.
   localparam int LINE_CAPACITY = 40;
   localparam int ADDR_W        = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
   localparam int LIMIT_W       = 6;
   localparam int CMP_W         = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;

   // Character constants.
   localparam logic [7:0] NEWLINE_KEY  = 8'd10;
   localparam logic [7:0] PRINT_LOW    = 8'h20;
   localparam logic [7:0] PRINT_HIGH   = 8'h7E;
   localparam logic [6:0] SPACE_CHAR   = 7'h20;

   // Register reset values.
   localparam logic [7:0]         ERASE_RESET = 8'd127;
   localparam logic [7:0]         KILL_RESET  = 8'd21;
   localparam logic [7:0]         WORD_RESET  = 8'd23;
   localparam logic [7:0]         END_RESET   = 8'd4;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd40;

   // Register map, by word index.
   typedef enum logic [2:0] {
      REG_ERASE = 3'd0,
      REG_KILL  = 3'd1,
      REG_WORD  = 3'd2,
      REG_END   = 3'd3,
      REG_LIMIT = 3'd4
   } reg_index_type;

   // Display actions carried by each result word.
   typedef enum logic [2:0] {
      ACT_ECHO    = 3'd0,
      ACT_RUB     = 3'd1,
      ACT_BELL    = 3'd2,
      ACT_NEWLINE = 3'd3,
      ACT_END     = 3'd4
   } action_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_KILL,
      S_WREAD,
      S_WEVAL,
      S_ECHO
   } state_type;

   // Configuration seen by the sequencer.
   typedef struct packed {
      logic [7:0]         erase_code;
      logic [7:0]         kill_code;
      logic [7:0]         word_erase_code;
      logic [7:0]         end_code;
      logic [LIMIT_W-1:0] line_limit;
   } cfg_type;

endpackage

// ===== rtl/tle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                                wr_data,
   input  logic                                            rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tle_csr.sv =====
// Configuration registers of the terminal line editor behind an APB-style port.
module tle_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output tle_pkg::cfg_type    cfg
);

   tle_pkg::cfg_type cfg_ff;
   tle_pkg::cfg_type cfg_in;
   logic             wr_strobe;
   logic [2:0]       reg_sel;

   assign wr_strobe = psel && penable && pwrite;
   assign reg_sel   = paddr[4:2];
   assign pready    = 1'b1;

   // Register write decode; writes beyond the map are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (reg_sel)
            tle_pkg::REG_ERASE: cfg_in.erase_code      = pwdata[7:0];
            tle_pkg::REG_KILL:  cfg_in.kill_code       = pwdata[7:0];
            tle_pkg::REG_WORD:  cfg_in.word_erase_code = pwdata[7:0];
            tle_pkg::REG_END:   cfg_in.end_code        = pwdata[7:0];
            tle_pkg::REG_LIMIT: cfg_in.line_limit      = pwdata[tle_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.erase_code      <= tle_pkg::ERASE_RESET;
         cfg_ff.kill_code       <= tle_pkg::KILL_RESET;
         cfg_ff.word_erase_code <= tle_pkg::WORD_RESET;
         cfg_ff.end_code        <= tle_pkg::END_RESET;
         cfg_ff.line_limit      <= tle_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_sel)
         tle_pkg::REG_ERASE: prdata = {24'd0, cfg_ff.erase_code};
         tle_pkg::REG_KILL:  prdata = {24'd0, cfg_ff.kill_code};
         tle_pkg::REG_WORD:  prdata = {24'd0, cfg_ff.word_erase_code};
         tle_pkg::REG_END:   prdata = {24'd0, cfg_ff.end_code};
         tle_pkg::REG_LIMIT: prdata = {{(32-tle_pkg::LIMIT_W){1'b0}}, cfg_ff.line_limit};
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tle_ctrl.sv =====
// Key sequencer: decodes each key, walks the line store and drives the result register.
module tle_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  tle_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_action,
   output logic [6:0]                      rsp_out_char,
   output logic                            rsp_last,
   output logic                            ram_wr_en,
   output logic [tle_pkg::ADDR_W-1:0]      ram_wr_addr,
   output logic [6:0]                      ram_wr_data,
   output logic                            ram_rd_en,
   output logic [tle_pkg::ADDR_W-1:0]      ram_rd_addr,
   input  logic [6:0]                      ram_rd_data
);

   tle_pkg::state_type          state_ff, state_in;
   logic [tle_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                        session_over_ff, session_over_in;
   logic [7:0]                  key_ff, key_in;
   logic                        word_phase_ff, word_phase_in;
   logic                        pending_ff, pending_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tle_pkg::action_type         rsp_action_ff, rsp_action_in;
   logic [6:0]                  rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        emit_ok;
   logic                        emit;
   tle_pkg::action_type         emit_action;
   logic [6:0]                  emit_char;
   logic                        emit_last;
   logic [tle_pkg::CMP_W-1:0]   lim_eff;
   logic [tle_pkg::CMP_W-1:0]   len_ext;
   logic                        line_full;
   logic                        len_zero;
   logic [tle_pkg::LEN_W-1:0]   len_dec;
   logic                        printable;
   logic                        rub_now;

   // The result register may take a new word when empty or being drained.
   assign emit_ok = !rsp_valid_ff || rsp_ready;

   // Effective line limit, clamped to one and to the store capacity.
   always_comb begin
      lim_eff = tle_pkg::CMP_W'(cfg.line_limit);
      if (cfg.line_limit == '0) begin
         lim_eff = tle_pkg::CMP_W'(1);
      end else if (tle_pkg::CMP_W'(cfg.line_limit) > tle_pkg::CMP_W'(tle_pkg::LINE_CAPACITY)) begin
         lim_eff = tle_pkg::CMP_W'(tle_pkg::LINE_CAPACITY);
      end
   end

   assign len_ext   = tle_pkg::CMP_W'(len_ff);
   assign line_full = len_ext >= lim_eff;
   assign len_zero  = (len_ff == '0);
   assign len_dec   = len_ff - tle_pkg::LEN_W'(1);
   assign printable = (key_ff >= tle_pkg::PRINT_LOW) && (key_ff <= tle_pkg::PRINT_HIGH);
   // In the word phase a space stops the walk; in the space phase every character is rubbed.
   assign rub_now   = !(word_phase_ff && (ram_rd_data == tle_pkg::SPACE_CHAR));

   assign ram_wr_addr = len_ff[tle_pkg::ADDR_W-1:0];
   assign ram_wr_data = key_ff[6:0];
   assign ram_rd_addr = len_dec[tle_pkg::ADDR_W-1:0];

   // Next state, store accesses and result words.
   always_comb begin
      state_in        = state_ff;
      len_in          = len_ff;
      session_over_in = session_over_ff;
      key_in          = key_ff;
      word_phase_in   = word_phase_ff;
      pending_in      = pending_ff;
      emit            = 1'b0;
      emit_action     = tle_pkg::ACT_BELL;
      emit_char       = 7'd0;
      emit_last       = 1'b1;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      req_ready       = 1'b0;

      unique case (state_ff)
         tle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in   = req_in_byte;
               state_in = tle_pkg::S_DECODE;
            end
         end

         tle_pkg::S_DECODE: begin
            if (session_over_ff) begin
               state_in = tle_pkg::S_IDLE;
            end else if (key_ff == cfg.erase_code) begin
               if (len_zero) begin
                  state_in = tle_pkg::S_IDLE;
               end else if (emit_ok) begin
                  emit        = 1'b1;
                  emit_action = tle_pkg::ACT_RUB;
                  len_in      = len_dec;
                  state_in    = tle_pkg::S_IDLE;
               end
            end else if (key_ff == cfg.kill_code) begin
               state_in = len_zero ? tle_pkg::S_IDLE : tle_pkg::S_KILL;
            end else if (key_ff == cfg.word_erase_code) begin
               word_phase_in = 1'b0;
               pending_in    = 1'b0;
               state_in      = len_zero ? tle_pkg::S_IDLE : tle_pkg::S_WREAD;
            end else if (key_ff == cfg.end_code) begin
               if (emit_ok) begin
                  emit        = 1'b1;
                  emit_action = len_zero ? tle_pkg::ACT_END : tle_pkg::ACT_BELL;
                  if (len_zero) begin
                     session_over_in = 1'b1;
                  end
                  state_in = tle_pkg::S_IDLE;
               end
            end else if (key_ff == tle_pkg::NEWLINE_KEY) begin
               state_in = tle_pkg::S_IDLE;
            end else if (printable) begin
               if (!line_full) begin
                  state_in = tle_pkg::S_ECHO;
               end else if (emit_ok) begin
                  // Hard wrap: newline first, then the key starts a fresh line.
                  emit        = 1'b1;
                  emit_action = tle_pkg::ACT_NEWLINE;
                  emit_last   = 1'b0;
                  len_in      = '0;
                  state_in    = tle_pkg::S_ECHO;
               end
            end else if (emit_ok) begin
               emit        = 1'b1;
               emit_action = tle_pkg::ACT_BELL;
               state_in    = tle_pkg::S_IDLE;
            end
         end

         tle_pkg::S_ECHO: begin
            if (emit_ok) begin
               emit        = 1'b1;
               emit_action = tle_pkg::ACT_ECHO;
               emit_char   = key_ff[6:0];
               ram_wr_en   = 1'b1;
               len_in      = len_ff + tle_pkg::LEN_W'(1);
               state_in    = tle_pkg::S_IDLE;
            end
         end

         tle_pkg::S_KILL: begin
            if (emit_ok) begin
               emit        = 1'b1;
               emit_action = tle_pkg::ACT_RUB;
               emit_last   = (len_ff == tle_pkg::LEN_W'(1));
               len_in      = len_dec;
               if (len_ff == tle_pkg::LEN_W'(1)) begin
                  state_in = tle_pkg::S_IDLE;
               end
            end
         end

         tle_pkg::S_WREAD: begin
            // Fetch the last held character, or close out once the line is empty.
            if (len_zero) begin
               if (emit_ok) begin
                  emit        = 1'b1;
                  emit_action = tle_pkg::ACT_RUB;
                  pending_in  = 1'b0;
                  state_in    = tle_pkg::S_IDLE;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = tle_pkg::S_WEVAL;
            end
         end

         tle_pkg::S_WEVAL: begin
            // A rub is held back one step so that the final one can carry the last flag.
            if (rub_now) begin
               if (!pending_ff || emit_ok) begin
                  emit          = pending_ff;
                  emit_action   = tle_pkg::ACT_RUB;
                  emit_last     = 1'b0;
                  pending_in    = 1'b1;
                  len_in        = len_dec;
                  word_phase_in = word_phase_ff || (ram_rd_data != tle_pkg::SPACE_CHAR);
                  state_in      = tle_pkg::S_WREAD;
               end
            end else if (emit_ok) begin
               emit        = pending_ff;
               emit_action = tle_pkg::ACT_RUB;
               pending_in  = 1'b0;
               state_in    = tle_pkg::S_IDLE;
            end
         end

         default: state_in = tle_pkg::S_IDLE;
      endcase
   end

   // Result register: loaded on a new word, emptied when taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_action_in = rsp_action_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = emit_action;
         rsp_char_in   = emit_char;
         rsp_last_in   = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tle_pkg::S_IDLE;
         len_ff          <= '0;
         session_over_ff <= 1'b0;
         pending_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         len_ff          <= len_in;
         session_over_ff <= session_over_in;
         pending_ff      <= pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      word_phase_ff <= word_phase_in;
      rsp_action_ff <= rsp_action_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_action   = rsp_action_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== rtl/terminal_line_editor.sv =====
// Top level of the terminal line editor: registers, sequencer and line store.
//
// Usage. Keys enter one word at a time on the req_ channel (valid/ready, byte
// in req_in_byte). Each key answers with zero or more display words on the
// rsp_ channel (action, out_char, last); last marks the final word of a key.
// The APB-style port holds the erase, kill, word-erase and end codes and the
// line limit; write it only while no key is being worked on.
// Sequencing. A key is taken in the idle cycle and decoded in the next.
// Erase, end and bell words are registered at the end of decode; an echo,
// with or without the newline of a hard wrap, is registered in the echo
// state. Kill emits one rub for each held character from the kill state.
// Word erase walks the line store through its registered read port, with a
// read state and an evaluate state per character rubbed, then closes out.
// Reset clears the codes to their defaults, empties the line and reopens a
// closed session; the line store itself is not cleared, and only characters
// below the current length are ever read. When the receiver stalls, the
// result register holds its word and the sequencer waits with it; no key is
// taken until the current one has produced all its words.
module terminal_line_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [6:0]  rsp_out_char,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   tle_pkg::cfg_type                 cfg;
   logic                             ram_wr_en;
   logic [tle_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic [6:0]                       ram_wr_data;
   logic                             ram_rd_en;
   logic [tle_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [6:0]                       ram_rd_data;

   // Configuration registers.
   tle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Line store.
   tle_ram #(
      .WIDTH (7),
      .DEPTH (tle_pkg::LINE_CAPACITY)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Key sequencer and result register.
   tle_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_action   (rsp_action),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

endmodule

// ===== dv/terminal_line_editor_tb.sv =====
// Self-checking testbench of the terminal line editor: directed and random key streams.
`timescale 1ns / 1ps

module terminal_line_editor_tb;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 3;
   localparam int SETTLE_CYCLES = 2 * tle_pkg::LINE_CAPACITY + 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_GAP       = 6;
   localparam int LONG_STALL    = 400;
   localparam int PHASE_KEYS    = 20;
   localparam int PHASES        = 6;

   // Role that a key takes once the editing codes have been applied.
   typedef enum {
      KEY_ERASE, KEY_KILL, KEY_WORD, KEY_END, KEY_NEWLINE, KEY_PRINT, KEY_BELL
   } key_role_type;

   // One display word on the result channel.
   typedef struct packed {
      tle_pkg::action_type action;
      logic [6:0]          out_char;
      logic                last;
   } display_word_type;

   localparam display_word_type RUB_WORD     = '{tle_pkg::ACT_RUB, 7'd0, 1'b0};
   localparam display_word_type BELL_WORD    = '{tle_pkg::ACT_BELL, 7'd0, 1'b0};
   localparam display_word_type NEWLINE_WORD = '{tle_pkg::ACT_NEWLINE, 7'd0, 1'b0};
   localparam display_word_type END_WORD     = '{tle_pkg::ACT_END, 7'd0, 1'b0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_action;
   logic [6:0]  rsp_out_char;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Our own copy of the editor: registers, line and session flag.
   tle_pkg::cfg_type shadow_cfg = '{tle_pkg::ERASE_RESET, tle_pkg::KILL_RESET,
                                    tle_pkg::WORD_RESET, tle_pkg::END_RESET,
                                    tle_pkg::LIMIT_RESET};
   logic [6:0]       line_chars [tle_pkg::LINE_CAPACITY];
   int unsigned      line_len = 0;
   bit               session_closed = 1'b0;
   display_word_type pending_words [$];

   int fault_count = 0;
   int cycle_count = 0;
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int long_stall_req = 0;

   terminal_line_editor u_top (.*);

   always #CLOCK_HALF clock = ~clock;

   // Decode order follows the editor: erase, kill, word erase, end, then the rest.
   function automatic key_role_type role_of(input logic [7:0] key);
      if (key == shadow_cfg.erase_code) return KEY_ERASE;
      if (key == shadow_cfg.kill_code) return KEY_KILL;
      if (key == shadow_cfg.word_erase_code) return KEY_WORD;
      if (key == shadow_cfg.end_code) return KEY_END;
      if (key == tle_pkg::NEWLINE_KEY) return KEY_NEWLINE;
      if (key >= tle_pkg::PRINT_LOW && key <= tle_pkg::PRINT_HIGH) return KEY_PRINT;
      return KEY_BELL;
   endfunction

   // The limit register is clamped into 1 .. LINE_CAPACITY.
   function automatic int unsigned wrap_point();
      if (shadow_cfg.line_limit == 0) return 1;
      if (shadow_cfg.line_limit > tle_pkg::LINE_CAPACITY) return tle_pkg::LINE_CAPACITY;
      return shadow_cfg.line_limit;
   endfunction

   function automatic bit closes_session(input logic [7:0] key);
      return !session_closed && line_len == 0 && role_of(key) == KEY_END;
   endfunction

   // Works out the display words of one key and advances the line.
   function automatic void apply_key(input logic [7:0] key);
      display_word_type words [$];
      display_word_type w;
      if (session_closed) return;
      case (role_of(key))
         KEY_ERASE: begin
            if (line_len > 0) begin
               line_len--;
               words.push_back(RUB_WORD);
            end
         end
         KEY_KILL: begin
            while (line_len > 0) begin
               line_len--;
               words.push_back(RUB_WORD);
            end
         end
         KEY_WORD: begin
            // Trailing spaces go first, then the word in front of them.
            while (line_len > 0 && line_chars[line_len - 1] == tle_pkg::SPACE_CHAR) begin
               line_len--;
               words.push_back(RUB_WORD);
            end
            while (line_len > 0 && line_chars[line_len - 1] != tle_pkg::SPACE_CHAR) begin
               line_len--;
               words.push_back(RUB_WORD);
            end
         end
         KEY_END: begin
            if (line_len == 0) begin
               session_closed = 1'b1;
               words.push_back(END_WORD);
            end else begin
               words.push_back(BELL_WORD);
            end
         end
         KEY_NEWLINE: ;
         KEY_PRINT: begin
            // A full line wraps hard and restarts with this key alone.
            if (line_len >= wrap_point()) begin
               words.push_back(NEWLINE_WORD);
               line_len = 0;
            end
            if (line_len < tle_pkg::LINE_CAPACITY) begin
               line_chars[line_len] = key[6:0];
               line_len++;
            end
            w = '{tle_pkg::ACT_ECHO, key[6:0], 1'b0};
            words.push_back(w);
         end
         default: words.push_back(BELL_WORD);
      endcase
      foreach (words[i]) begin
         w = words[i];
         w.last = (i == words.size() - 1);
         pending_words.push_back(w);
      end
   endfunction

   function automatic logic [31:0] reg_image(input logic [2:0] index);
      case (index)
         tle_pkg::REG_ERASE: return {24'd0, shadow_cfg.erase_code};
         tle_pkg::REG_KILL:  return {24'd0, shadow_cfg.kill_code};
         tle_pkg::REG_WORD:  return {24'd0, shadow_cfg.word_erase_code};
         tle_pkg::REG_END:   return {24'd0, shadow_cfg.end_code};
         tle_pkg::REG_LIMIT: return {26'd0, shadow_cfg.line_limit};
         default:            return '0;
      endcase
   endfunction

   // Mostly lower-case words with spaces, now and then any printable key.
   function automatic logic [7:0] typed_char();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) return tle_pkg::PRINT_LOW;
      if (pick < 9) return 8'($urandom_range(97, 122));
      return 8'($urandom_range(tle_pkg::PRINT_LOW, tle_pkg::PRINT_HIGH));
   endfunction

   function automatic logic [7:0] control_code();
      if ($urandom_range(0, 1)) return 8'($urandom_range(0, tle_pkg::PRINT_LOW - 1));
      return 8'($urandom_range(tle_pkg::PRINT_HIGH + 1, 255));
   endfunction

   function automatic logic [7:0] any_code();
      return 8'($urandom_range(0, 255));
   endfunction

   // Offers one key, holds it until taken, then predicts its display words.
   task automatic send_key(input logic [7:0] key);
      int gap;
      gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_key(key);
   endtask

   // Random keys never close the session; that is left to its own test.
   task automatic send_typed(input logic [7:0] key, inout int keys);
      while (closes_session(key)) key = typed_char();
      send_key(key);
      if (key != tle_pkg::NEWLINE_KEY) keys++;
   endtask

   // Waits until every display word is in and the editor has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (index)
         tle_pkg::REG_ERASE: shadow_cfg.erase_code = value[7:0];
         tle_pkg::REG_KILL:  shadow_cfg.kill_code = value[7:0];
         tle_pkg::REG_WORD:  shadow_cfg.word_erase_code = value[7:0];
         tle_pkg::REG_END:   shadow_cfg.end_code = value[7:0];
         tle_pkg::REG_LIMIT: shadow_cfg.line_limit = value[tle_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(input logic [2:0] index, output logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [31:0] got;
      for (int i = tle_pkg::REG_ERASE; i <= tle_pkg::REG_LIMIT; i++) begin
         csr_read(3'(i), got);
         if (got !== reg_image(3'(i))) begin
            $error("register %0d: expected %0h, got %0h", i, reg_image(3'(i)), got);
            fault_count++;
         end
      end
   endtask

   // Writes all five registers, with noise in the unused upper bits.
   task automatic program_editor(input logic [7:0] erase_key, kill_key, word_key, stop_key,
                                 input logic [5:0] limit);
      csr_write(tle_pkg::REG_ERASE, {24'($urandom()), erase_key});
      csr_write(tle_pkg::REG_KILL, {24'($urandom()), kill_key});
      csr_write(tle_pkg::REG_WORD, {24'($urandom()), word_key});
      csr_write(tle_pkg::REG_END, {24'($urandom()), stop_key});
      csr_write(tle_pkg::REG_LIMIT, {26'($urandom()), limit});
      check_registers();
   endtask

   // One burst of typing followed by an editing key, or a few noise bytes.
   task automatic type_sequence(inout int keys);
      int run_len;
      int pick;
      logic [7:0] key;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 4)) send_typed(any_code(), keys);
      end else begin
         run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(20, 45);
         repeat (run_len) send_typed(typed_char(), keys);
         pick = $urandom_range(0, 10);
         if (pick < 3) key = shadow_cfg.erase_code;
         else if (pick < 5) key = shadow_cfg.kill_code;
         else if (pick < 8) key = shadow_cfg.word_erase_code;
         else if (pick < 9) key = shadow_cfg.end_code;
         else if (pick < 10) key = tle_pkg::NEWLINE_KEY;
         else key = any_code();
         send_typed(key, keys);
      end
   endtask

   // Reset values, then writes beyond the register map, which must change nothing.
   task automatic test_register_map();
      check_registers();
      for (int k = int'(tle_pkg::REG_LIMIT) + 1; k < 8; k++) csr_write(3'(k), $urandom());
      check_registers();
   endtask

   // Field extremes, bells, newline and every edit at the reset codes.
   task automatic test_basic_editing();
      logic [7:0] keys [23] = '{tle_pkg::PRINT_LOW, tle_pkg::PRINT_HIGH, "a",
                                tle_pkg::NEWLINE_KEY, 8'd0, 8'(tle_pkg::PRINT_LOW - 8'd1),
                                8'd128, 8'd255, tle_pkg::END_RESET, tle_pkg::ERASE_RESET,
                                tle_pkg::WORD_RESET, tle_pkg::WORD_RESET,
                                tle_pkg::WORD_RESET, tle_pkg::ERASE_RESET,
                                tle_pkg::KILL_RESET, "x", "y", " ", " ",
                                tle_pkg::WORD_RESET, "p", "q", tle_pkg::KILL_RESET};
      foreach (keys[i]) send_key(keys[i]);
   endtask

   // Codes that coincide act as the earliest of them; a match beats newline.
   task automatic test_key_priority();
      settle();
      program_editor("A", "A", "A", "A", tle_pkg::LIMIT_RESET);
      send_key("b");
      send_key("A");
      settle();
      program_editor(8'd8, "A", "A", "A", tle_pkg::LIMIT_RESET);
      send_key("c");
      send_key("d");
      send_key("A");
      settle();
      program_editor(8'd8, 8'd9, tle_pkg::NEWLINE_KEY, "A", tle_pkg::LIMIT_RESET);
      send_key("e");
      send_key(" ");
      send_key("f");
      send_key(tle_pkg::NEWLINE_KEY);
      send_key("A");
      send_key(tle_pkg::ERASE_RESET);
      send_key(8'd8);
   endtask

   // A line already longer than a newly lowered limit counts as full.
   task automatic test_lowered_limit();
      settle();
      program_editor(tle_pkg::ERASE_RESET, tle_pkg::KILL_RESET, tle_pkg::WORD_RESET,
                     tle_pkg::END_RESET, tle_pkg::LIMIT_RESET);
      send_key("a");
      send_key("b");
      send_key("c");
      settle();
      csr_write(tle_pkg::REG_LIMIT, 32'd1);
      send_key("z");
      send_key("w");
   endtask

   // The receiver stops for a long while so that the editor stalls its input.
   task automatic test_output_stall();
      settle();
      program_editor(tle_pkg::ERASE_RESET, tle_pkg::KILL_RESET, tle_pkg::WORD_RESET,
                     tle_pkg::END_RESET, tle_pkg::LIMIT_RESET);
      sender_gaps = 1'b0;
      long_stall_req = LONG_STALL;
      repeat (30) send_key(typed_char());
      send_key(tle_pkg::KILL_RESET);
      repeat (10) send_key(typed_char());
      send_key(tle_pkg::WORD_RESET);
      sender_gaps = 1'b1;
   endtask

   // Random typing under a range of codes and limits, idling switched per phase.
   task automatic test_random_editing();
      int keys;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: program_editor(tle_pkg::ERASE_RESET, tle_pkg::KILL_RESET, tle_pkg::WORD_RESET,
                              tle_pkg::END_RESET, tle_pkg::LIMIT_RESET);
            1: program_editor(8'd0, 8'd255, control_code(), control_code(), 6'd1);
            2: program_editor(control_code(), control_code(), control_code(), control_code(),
                              6'd0);
            3: program_editor(any_code(), any_code(), any_code(), any_code(), 6'd63);
            4: program_editor(tle_pkg::ERASE_RESET, tle_pkg::KILL_RESET, tle_pkg::WORD_RESET,
                              tle_pkg::END_RESET,
                              6'($urandom_range(2, tle_pkg::LINE_CAPACITY - 1)));
            default: program_editor(any_code(), any_code(), any_code(), any_code(),
                                    6'(tle_pkg::LINE_CAPACITY));
         endcase
         sender_gaps = !(phase == 1 || phase == 4);
         receiver_gaps = !(phase == 2 || phase == 4);
         keys = 0;
         while (keys < PHASE_KEYS) type_sequence(keys);
      end
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // End on an empty line closes the session; nothing answers after that.
   task automatic test_session_end();
      settle();
      program_editor(tle_pkg::ERASE_RESET, tle_pkg::KILL_RESET, tle_pkg::WORD_RESET,
                     tle_pkg::END_RESET, tle_pkg::LIMIT_RESET);
      send_key(tle_pkg::KILL_RESET);
      send_key(tle_pkg::END_RESET);
      send_key("a");
      send_key(tle_pkg::END_RESET);
      send_key(tle_pkg::ERASE_RESET);
      send_key(8'hFF);
   endtask

   // Receiver: takes each display word, checks it and draws its next stall.
   initial begin
      display_word_type want;
      display_word_type got;
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = '{tle_pkg::action_type'(rsp_action), rsp_out_char, rsp_last};
            if (pending_words.size() == 0) begin
               $error("display word with none expected: action %0d, char %0h",
                      got.action, got.out_char);
               fault_count++;
            end else begin
               want = pending_words.pop_front();
               if (got.action !== want.action) begin
                  $error("action: expected %0d, got %0d", want.action, got.action);
                  fault_count++;
               end
               if (got.out_char !== want.out_char) begin
                  $error("out_char: expected %0h, got %0h", want.out_char, got.out_char);
                  fault_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, got.last);
                  fault_count++;
               end
            end
            stall_left = receiver_gaps ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (long_stall_req > 0) begin
            stall_left = long_stall_req;
            long_stall_req = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_map();
      test_basic_editing();
      test_key_priority();
      test_lowered_limit();
      test_output_stall();
      test_random_editing();
      test_session_end();
      settle();
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
